>>> design/recurrence_blob_stream_parser_top_assert.svh
// Assertion helpers for the recurrence blob parser
`ifndef RECURRENCE_BLOB_STREAM_PARSER_TOP_ASSERT_SVH
`define RECURRENCE_BLOB_STREAM_PARSER_TOP_ASSERT_SVH
`define RBP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define RBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> design/rbsp_pkg.sv
`default_nettype none
package rbsp_pkg;
  localparam int TimeW = 39;
  localparam logic [15:0] VersionHighlight = 16'h3009;
  localparam logic [38:0] TimeShift = 39'd11644473600;
  localparam logic [15:0] PatternDay = 16'h0000;
  localparam logic [15:0] PatternMonthNth = 16'h0003;

  typedef enum logic [2:0] {
    REC_DELETED = 3'd0,
    REC_EXCEPTION = 3'd1,
    REC_TEXT = 3'd2,
    REC_DONE = 3'd3,
    REC_TRUNC = 3'd4,
    REC_TOO_MANY = 3'd5
  } rec_kind_t;

  typedef enum logic [5:0] {
    PH_READER, PH_WRITER, PH_FREQ, PH_PATTERN, PH_CALTYPE, PH_FIRSTDT,
    PH_PERIOD, PH_SLIDING, PH_PTS, PH_N, PH_ENDTYPE, PH_OCC, PH_FIRSTDOW,
    PH_DELCOUNT, PH_DELDATE, PH_MODCOUNT, PH_MODDATE, PH_STARTDATE,
    PH_ENDDATE, PH_READER2, PH_WRITER2, PH_STARTOFF, PH_ENDOFF, PH_EXCOUNT,
    PH_EI_START, PH_EI_END, PH_EI_ORIG, PH_EI_FLAGS, PH_SUBJLEN, PH_SUBJLEN2,
    PH_SUBJTEXT, PH_MEET, PH_RDELTA, PH_REMIND, PH_LOCLEN, PH_LOCLEN2,
    PH_LOCTEXT, PH_BUSY, PH_ATTACH, PH_SUBTYPE, PH_COLOR,
    PH_RB1SIZE, PH_RB1DATA,
    PH_CHSIZE, PH_CHVALUE, PH_CHRES, PH_EE1SIZE, PH_EE1DATA, PH_EE_START,
    PH_EE_END, PH_EE_ORIG, PH_WSUBJLEN, PH_WSUBJTEXT, PH_WLOCLEN,
    PH_WLOCTEXT, PH_EE2SIZE, PH_EE2DATA,
    PH_RB2SIZE, PH_RB2DATA, PH_IDLE
  } phase_t;

  // raw record passed from the parser to the formatter
  typedef struct packed {
    rec_kind_t kind;
    logic [7:0] index;
    logic [31:0] t0;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [15:0] mask;
    logic [1:0] src;
    logic [7:0] value;
  } raw_rec_t;
endpackage
`default_nettype wire

>>> design/recurrence_blob_stream_parser_top.sv
// Recurrence blob parser.
// Input: one blob byte per word on in_valid/in_ready with data_byte and
// last_byte; last_byte ends the blob and re-arms the parser.
// Output: records on out_valid/out_ready: deleted dates, exception times,
// text bytes, and a done, truncated or too-many-exceptions record.
// Throughput: one byte per cycle while the record queue has room; each
// byte is classified by the front parser in the cycle it is accepted.
// A record is presented after the byte that causes it is accepted: it is
// written into the queue, then taken through the minutes-to-seconds
// conversion register, and it waits longer while the receiver stalls.
// A two-entry record queue sits between parser and formatter; when the
// receiver stalls the queue fills and in_ready drops, no record is lost.
// Per-exception subject/location flags live in a small RAM with a registered
// read, addressed ahead by the exception that the next byte will use.
// Reset (rst, synchronous) returns the parser to the first header field and
// empties the queue; no clearing pass is needed.
`default_nettype none
module recurrence_blob_stream_parser_top #(
  parameter int MAX_EXCEPTIONS = 256
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_ready,
  input wire logic [7:0] data_byte,
  input wire logic last_byte,
  output logic out_valid,
  input wire logic out_ready,
  output logic [2:0] record_kind,
  output logic [7:0] exception_index,
  output logic signed [38:0] first_time_secs,
  output logic signed [38:0] start_secs,
  output logic signed [38:0] end_secs,
  output logic [15:0] override_mask,
  output logic [1:0] text_source,
  output logic [7:0] text_value
);
  import rbsp_pkg::*;
  logic rec_valid, room;
  raw_rec_t rec;

  rbsp_front #(.MaxExceptions(MAX_EXCEPTIONS)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .last_byte(last_byte),
    .rec_valid(rec_valid), .rec(rec), .q_has_room(room)
  );

  rbsp_back u_back (
    .clk(clk), .rst(rst), .rec_valid(rec_valid), .rec(rec), .q_has_room(room),
    .out_valid(out_valid), .out_ready(out_ready),
    .record_kind(record_kind), .exception_index(exception_index),
    .first_time_secs(first_time_secs), .start_secs(start_secs), .end_secs(end_secs),
    .override_mask(override_mask), .text_source(text_source), .text_value(text_value)
  );
endmodule
`default_nettype wire

>>> design/rbsp_ram.sv
`default_nettype none
module rbsp_ram #(
  parameter int Width = 2,
  parameter int Depth = 256
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(Depth)-1:0] waddr,
  input wire logic [Width-1:0] wdata,
  input wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> design/rbsp_front.sv
`default_nettype none
module rbsp_front #(
  parameter int MaxExceptions = 256
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_ready,
  input wire logic [7:0] data_byte,
  input wire logic last_byte,
  output logic rec_valid,
  output rbsp_pkg::raw_rec_t rec,
  input wire logic q_has_room
);
  import rbsp_pkg::*;
  localparam int AW = (MaxExceptions > 1) ? $clog2(MaxExceptions) : 1;

  phase_t phase, p_next, phase_next;
  logic [1:0] bif, bif_next;
  logic [31:0] acc, acc_next, items, items_next, skip, skip_next;
  logic [15:0] pkind, pkind_next, extot, extot_next, cur, cur_next, flags, flags_next;
  logic [31:0] wv2, wv2_next;
  logic [31:0] ht0, ht1, ht2, ht0_n, ht1_n, ht2_n;
  logic emit;
  raw_rec_t r;
  logic fw_we;
  logic [1:0] fw_d, fr_q;
  logic [AW-1:0] fw_a, fr_a;
  logic [1:0] sflags;
  logic [31:0] v;
  logic done_f, blk;
  logic [3:0] k;
  logic fire;

  assign in_ready = q_has_room;
  assign fire = in_valid && in_ready;

  rbsp_ram #(.Width(2), .Depth(1 << AW)) u_flags (
    .clk(clk), .we(fw_we), .waddr(fw_a), .wdata(fw_d), .raddr(fr_a), .rdata(fr_q)
  );
  // read ahead: the address is the exception that the next byte will use
  assign fr_a = cur_next[AW-1:0];
  assign sflags = (cur < 16'(MaxExceptions)) ? fr_q : 2'b00;

  function automatic logic [15:0] opt_mask(input logic [3:0] i);
    opt_mask = 16'(1) << i;
  endfunction

  function automatic phase_t opt_phase(input logic [3:0] i);
    case (i)
      4'd0: opt_phase = PH_SUBJLEN;
      4'd1: opt_phase = PH_MEET;
      4'd2: opt_phase = PH_RDELTA;
      4'd3: opt_phase = PH_REMIND;
      4'd4: opt_phase = PH_LOCLEN;
      4'd5: opt_phase = PH_BUSY;
      4'd6: opt_phase = PH_ATTACH;
      4'd7: opt_phase = PH_SUBTYPE;
      default: opt_phase = PH_COLOR;
    endcase
  endfunction

  always_comb begin
    logic [15:0] fl;
    logic [15:0] cinc;
    logic found;
    logic [31:0] n;
    phase_t lp;
    fl = 16'd0;
    cinc = 16'd0;
    found = 1'b0;
    n = 32'd0;
    lp = PH_IDLE;
    phase_next = phase;
    bif_next = bif;
    acc_next = acc;
    items_next = items;
    skip_next = skip;
    pkind_next = pkind;
    wv2_next = wv2;
    extot_next = extot;
    cur_next = cur;
    flags_next = flags;
    ht0_n = ht0; ht1_n = ht1; ht2_n = ht2;
    emit = 1'b0;
    r = '0;
    r.kind = REC_DONE;
    fw_we = 1'b0;
    fw_a = cur[AW-1:0];
    fw_d = 2'b00;
    v = acc | (32'(data_byte) << {bif, 3'b000});
    blk = (phase == PH_SUBJTEXT) || (phase == PH_LOCTEXT) || (phase == PH_WSUBJTEXT) ||
          (phase == PH_WLOCTEXT) || (phase == PH_CHRES) || (phase == PH_EE1DATA) ||
          (phase == PH_EE2DATA) || (phase == PH_RB1DATA) || (phase == PH_RB2DATA);
    case (phase)
      PH_READER, PH_WRITER, PH_FREQ, PH_PATTERN, PH_CALTYPE, PH_EXCOUNT, PH_EI_FLAGS,
      PH_SUBJLEN, PH_SUBJLEN2, PH_LOCLEN, PH_LOCLEN2, PH_WSUBJLEN, PH_WLOCLEN:
        done_f = (bif == 2'd1);
      default: done_f = (bif == 2'd3);
    endcase
    k = 4'd15;
    p_next = PH_IDLE;
    if (fire && phase != PH_IDLE) begin
      lp = PH_IDLE;
      if (blk) begin
        if (phase == PH_SUBJTEXT || phase == PH_LOCTEXT || phase == PH_WSUBJTEXT ||
            phase == PH_WLOCTEXT) begin
          emit = 1'b1;
          r.kind = REC_TEXT;
          r.index = cur[7:0];
          r.value = data_byte;
          r.src = (phase == PH_SUBJTEXT) ? 2'd0 : (phase == PH_LOCTEXT) ? 2'd1 :
                  (phase == PH_WSUBJTEXT) ? 2'd2 : 2'd3;
        end
        n = (skip != 0) ? skip - 32'd1 : 32'd0;
        skip_next = n;
        if (n == 0) lp = phase;
      end else if (!done_f) begin
        acc_next = v;
        bif_next = bif + 2'd1;
      end else begin
        bif_next = 2'd0;
        acc_next = 32'd0;
        phase_next = phase_t'(phase + 6'd1);
        case (phase)
          PH_PATTERN: begin pkind_next = v[15:0]; phase_next = PH_CALTYPE; end
          PH_SLIDING: phase_next = (pkind != PatternDay) ? PH_PTS : PH_ENDTYPE;
          PH_PTS: phase_next = (pkind == PatternMonthNth) ? PH_N : PH_ENDTYPE;
          PH_DELCOUNT: begin
            if (v == 0) lp = PH_DELDATE;
            else begin items_next = v; phase_next = PH_DELDATE; end
          end
          PH_DELDATE: begin
            emit = 1'b1;
            r.kind = REC_DELETED;
            r.t0 = v;
            items_next = items - 32'd1;
            phase_next = PH_DELDATE;
            if (items == 32'd1) lp = PH_DELDATE;
          end
          PH_MODCOUNT: begin
            if (v == 0) lp = PH_MODDATE;
            else begin items_next = v; phase_next = PH_MODDATE; end
          end
          PH_MODDATE: begin
            items_next = items - 32'd1;
            phase_next = PH_MODDATE;
            if (items == 32'd1) lp = PH_MODDATE;
          end
          PH_WRITER2: wv2_next = v;
          PH_EXCOUNT: begin
            if (v > 32'(MaxExceptions)) begin
              emit = 1'b1;
              r.kind = REC_TOO_MANY;
              phase_next = PH_IDLE;
            end else begin
              extot_next = v[15:0];
              cur_next = 16'd0;
              phase_next = (v != 0) ? PH_EI_START : PH_RB1SIZE;
            end
          end
          PH_EI_START: ht0_n = v;
          PH_EI_END: ht1_n = v;
          PH_EI_ORIG: ht2_n = v;
          PH_EI_FLAGS: begin
            flags_next = v[15:0];
            fl = v[15:0];
            fw_we = (cur < 16'(MaxExceptions));
            fw_d = {v[4], v[0]};
            emit = 1'b1;
            r.kind = REC_EXCEPTION;
            r.index = cur[7:0];
            r.t0 = ht2; r.t1 = ht0; r.t2 = ht1;
            r.mask = v[15:0];
            k = 4'd0;
          end
          PH_SUBJLEN2: begin
            if (v == 0) lp = PH_SUBJTEXT;
            else begin skip_next = v; phase_next = PH_SUBJTEXT; end
          end
          PH_MEET: begin fl = flags; k = 4'd2; end
          PH_RDELTA: begin fl = flags; k = 4'd3; end
          PH_REMIND: begin fl = flags; k = 4'd4; end
          PH_LOCLEN2: begin
            if (v == 0) lp = PH_LOCTEXT;
            else begin skip_next = v; phase_next = PH_LOCTEXT; end
          end
          PH_BUSY: begin fl = flags; k = 4'd6; end
          PH_ATTACH: begin fl = flags; k = 4'd7; end
          PH_SUBTYPE: begin fl = flags; k = 4'd8; end
          PH_COLOR: begin fl = flags; k = 4'd10; end
          PH_RB1SIZE, PH_EE1SIZE, PH_EE2SIZE, PH_RB2SIZE: begin
            p_next = phase_t'(phase + 6'd1);
            if (v == 0) lp = p_next;
            else begin skip_next = v; phase_next = p_next; end
          end
          PH_CHSIZE: begin
            if (wv2 >= 32'(VersionHighlight) && v != 0) begin
              skip_next = v;
              phase_next = PH_CHVALUE;
            end else phase_next = PH_EE1SIZE;
          end
          PH_CHVALUE: begin
            n = (skip > 32'd4) ? skip - 32'd4 : 32'd0;
            if (n == 0) lp = PH_CHRES;
            else begin skip_next = n; phase_next = PH_CHRES; end
          end
          PH_EE_START: ht0_n = v;
          PH_EE_END: ht1_n = v;
          PH_EE_ORIG: begin
            ht2_n = v;
            phase_next = sflags[0] ? PH_WSUBJLEN : sflags[1] ? PH_WLOCLEN : PH_EE2SIZE;
          end
          PH_WSUBJLEN, PH_WLOCLEN: begin
            p_next = phase_t'(phase + 6'd1);
            n = {v[30:0], 1'b0};
            if (n == 0) lp = p_next;
            else begin skip_next = n; phase_next = p_next; end
          end
          default: ;
        endcase
      end
      // leave a finished block or list
      cinc = cur + 16'd1;
      case (lp)
        PH_DELDATE: phase_next = PH_MODCOUNT;
        PH_MODDATE: phase_next = PH_STARTDATE;
        PH_SUBJTEXT: begin fl = flags; k = 4'd1; end
        PH_LOCTEXT: begin fl = flags; k = 4'd5; end
        PH_RB1DATA: begin
          cur_next = 16'd0;
          phase_next = (extot != 0) ? PH_CHSIZE : PH_RB2SIZE;
        end
        PH_CHRES: phase_next = PH_EE1SIZE;
        PH_EE1DATA: begin
          if (sflags != 2'b00) phase_next = PH_EE_START;
          else begin
            cur_next = cinc;
            phase_next = (cinc < extot) ? PH_CHSIZE : PH_RB2SIZE;
          end
        end
        PH_WSUBJTEXT: phase_next = sflags[1] ? PH_WLOCLEN : PH_EE2SIZE;
        PH_WLOCTEXT: phase_next = PH_EE2SIZE;
        PH_EE2DATA: begin
          cur_next = cinc;
          phase_next = (cinc < extot) ? PH_CHSIZE : PH_RB2SIZE;
        end
        PH_RB2DATA: begin
          emit = 1'b1;
          r = '0;
          r.kind = REC_DONE;
          phase_next = PH_IDLE;
        end
        default: ;
      endcase
      if (k <= 4'd9) begin
        for (int i = 0; i < 9; i++) begin
          if (!found && 4'(i) >= k && (fl & opt_mask(4'(i))) != 0) begin
            found = 1'b1;
            phase_next = opt_phase(4'(i));
          end
        end
        if (!found) begin
          cur_next = cinc;
          phase_next = (cinc < extot) ? PH_EI_START : PH_RB1SIZE;
        end
      end else if (k == 4'd10) begin
        cur_next = cinc;
        phase_next = (cinc < extot) ? PH_EI_START : PH_RB1SIZE;
      end
      if (phase_next != phase) begin
        bif_next = 2'd0;
        acc_next = 32'd0;
      end
      if (last_byte) begin
        if (!emit || r.kind == REC_DELETED || r.kind == REC_EXCEPTION ||
            r.kind == REC_TEXT) begin
          r = '0;
          r.kind = REC_TRUNC;
        end
        emit = 1'b1;
      end
    end
    if (fire && last_byte) begin
      phase_next = PH_READER;
      bif_next = 2'd0; acc_next = 32'd0; items_next = 32'd0; skip_next = 32'd0;
      pkind_next = 16'd0; wv2_next = 32'd0; extot_next = 16'd0; cur_next = 16'd0;
      flags_next = 16'd0; ht0_n = 32'd0; ht1_n = 32'd0; ht2_n = 32'd0;
    end
  end

  assign rec_valid = emit;
  assign rec = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_READER;
      bif <= 2'd0; acc <= 32'd0; items <= 32'd0; skip <= 32'd0;
      pkind <= 16'd0; wv2 <= 32'd0; extot <= 16'd0; cur <= 16'd0; flags <= 16'd0;
      ht0 <= 32'd0; ht1 <= 32'd0; ht2 <= 32'd0;
    end else begin
      phase <= phase_next;
      bif <= bif_next; acc <= acc_next; items <= items_next; skip <= skip_next;
      pkind <= pkind_next; wv2 <= wv2_next; extot <= extot_next; cur <= cur_next;
      flags <= flags_next;
      ht0 <= ht0_n; ht1 <= ht1_n; ht2 <= ht2_n;
    end
  end

`include "recurrence_blob_stream_parser_top_assert.svh"
  `RBP_ASSERT_NEXT(a_rearm, clk, rst, fire && last_byte, phase == PH_READER, "no re-arm")
  `RBP_ASSERT_IMPL(a_last_emits, clk, rst, fire && last_byte && phase != PH_IDLE, rec_valid,
    "last byte without record")
  `RBP_ASSERT_NEXT(a_idle_hold, clk, rst, phase == PH_IDLE && !(fire && last_byte),
    phase == PH_IDLE, "left idle")
endmodule
`default_nettype wire

>>> design/rbsp_back.sv
`default_nettype none
module rbsp_back (
  input wire logic clk,
  input wire logic rst,
  input wire logic rec_valid,
  input wire rbsp_pkg::raw_rec_t rec,
  output logic q_has_room,
  output logic out_valid,
  input wire logic out_ready,
  output logic [2:0] record_kind,
  output logic [7:0] exception_index,
  output logic signed [38:0] first_time_secs,
  output logic signed [38:0] start_secs,
  output logic signed [38:0] end_secs,
  output logic [15:0] override_mask,
  output logic [1:0] text_source,
  output logic [7:0] text_value
);
  import rbsp_pkg::*;
  // two-entry queue of raw records, then a registered conversion stage
  raw_rec_t q [2];
  logic [1:0] cnt;
  logic wp, rp;
  logic push, pop, conv_free;
  raw_rec_t h;

  assign push = rec_valid && q_has_room;
  assign conv_free = !out_valid || out_ready;
  assign pop = (cnt != 2'd0) && conv_free;
  assign q_has_room = (cnt != 2'd2) || pop;
  assign h = q[rp];

  function automatic logic [38:0] secs(input logic [31:0] m, input logic use_it);
    logic [38:0] s;
    s = ({7'd0, m} << 6) - ({7'd0, m} << 2) - TimeShift;
    secs = use_it ? s : 39'd0;
  endfunction

  always_ff @(posedge clk) begin
    if (push) q[wp] <= rec;
    if (pop) begin
      record_kind <= h.kind;
      exception_index <= h.index;
      first_time_secs <= secs(h.t0, h.kind == REC_DELETED || h.kind == REC_EXCEPTION);
      start_secs <= secs(h.t1, h.kind == REC_EXCEPTION);
      end_secs <= secs(h.t2, h.kind == REC_EXCEPTION);
      override_mask <= h.mask;
      text_source <= h.src;
      text_value <= h.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0; wp <= 1'b0; rp <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
      if (pop) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

`include "recurrence_blob_stream_parser_top_assert.svh"
  `RBP_ASSERT_IMPL(a_no_overflow, clk, rst, cnt == 2'd2 && !pop, !push, "queue overflow")
  `RBP_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(record_kind), "output dropped")
endmodule
`default_nettype wire
